// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned CNT_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Command broadcast to every cell in the execute cycle
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

  // Compare flags a cell reports to its neighbor and to the top level
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One storage cell of the sorted chain: compare against the key, hold or shift.
`default_nettype none

module spq_cell (
  input  logic                               clk,
  input  spq_pkg::cell_ctrl_t                ctrl,
  input  logic                               occupied,
  input  logic                               left_lt,
  input  logic signed [spq_pkg::KEY_W-1:0]   left_val,
  input  logic signed [spq_pkg::KEY_W-1:0]   right_val,
  output spq_pkg::cell_flags_t               flags,
  output logic signed [spq_pkg::KEY_W-1:0]   val,
  output logic signed [spq_pkg::KEY_W-1:0]   val_next
);
  import spq_pkg::*;

  // Compare the stored entry against the key; empty cells never match
  always_comb begin
    flags.lt = occupied && (val < ctrl.key);
    flags.eq = occupied && (val == ctrl.key);
  end

  // Pick the new entry: hold below the boundary, load or shift above it
  always_comb begin
    val_next = val;
    if (ctrl.ins && !flags.lt) begin
      val_next = left_lt ? ctrl.key : left_val;
    end else if (ctrl.rem && !flags.lt) begin
      val_next = right_val;
    end
  end

  // Entry register, written only on a changing operation
  always_ff @(posedge clk) begin
    if (ctrl.ins || ctrl.rem) begin
      val <= val_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spq_enc.sv =====
// Boundary encoder: index of the first cell whose entry is not below the key.
`default_nettype none

module spq_enc #(
  parameter int unsigned DEPTH = 16
) (
  input  logic [DEPTH-1:0]         lt,
  output logic [$clog2(DEPTH)-1:0] pos
);
  import spq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  logic [DEPTH-1:0] boundary;

  // Mark the single cell where the below-key run ends
  always_comb begin
    boundary[0] = !lt[0];
    for (int i = 1; i < DEPTH; i++) begin
      boundary[i] = lt[i-1] && !lt[i];
    end
  end

  // OR together the indexes of the marked cell
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (boundary[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: command register, cell chain, result register.
`default_nettype none

// Sorted priority queue holding up to DEPTH signed 32-bit keys, smallest first, in a
// chain of cells. Each beat is one operation (mode 0 insert, 1 remove first equal,
// 2 or 3 find) and yields exactly one result beat with status, position of the
// affected entry, smallest entry and entry count after the operation. An item passes
// through two steps: the beat is captured, then every cell compares its entry with
// the key and loads, holds or shifts from a neighbor, while the boundary encoder
// forms the position. One item executes at a time: no new beat is taken while one
// executes or while a stalled result waits; the path through the cell compares and
// the DEPTH-wide boundary encoder sets the clock period. The entry store needs no
// clearing: only entries below the count are ever looked at.
module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [spq_pkg::MODE_W-1:0]           mode,
  input  logic signed [spq_pkg::KEY_W-1:0]     value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [spq_pkg::STATUS_W-1:0]         status,
  output logic [spq_pkg::POS_W-1:0]            position,
  output logic signed [spq_pkg::KEY_W-1:0]     head_value,
  output logic                                 queue_empty,
  output logic [spq_pkg::CNT_W-1:0]            entry_count
);
  import spq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Control and command registers
  logic                    busy;
  logic [MODE_W-1:0]       cmd_mode;
  logic signed [KEY_W-1:0] cmd_key;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;

  // Chain wiring
  cell_ctrl_t              ctrl;
  logic [DEPTH-1:0]        lt_vec;
  logic [DEPTH-1:0]        eq_vec;
  logic [DEPTH-1:0]        occ_vec;
  logic signed [KEY_W-1:0] cell_val [DEPTH];
  logic signed [KEY_W-1:0] cell_nxt [DEPTH];
  cell_flags_t             cell_flg [DEPTH];

  logic [PW-1:0]           enc_pos;
  logic                    full;
  logic                    found;
  logic                    do_ins;
  logic                    do_rem;
  status_t                 res_status;
  logic [PW-1:0]           res_pos;
  logic [31:0]             res_pos_wide;
  logic [31:0]             res_cnt_wide;

  logic in_beat;
  assign in_beat  = in_valid && !in_stall;
  assign in_stall = busy || (out_valid && out_stall);

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_mode <= mode;
      cmd_key  <= value;
    end
  end

  // Occupancy of each cell follows from the count
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ_vec[i] = (CW'(i) < count);
    end
  end

  // Cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                    left_lt;
    logic signed [KEY_W-1:0] left_val;
    logic signed [KEY_W-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = cmd_key;
    end else begin : g_inner
      assign left_lt  = lt_vec[g-1];
      assign left_val = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_val = cell_val[g];
    end else begin : g_mid
      assign right_val = cell_val[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ_vec[g]),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .flags     (cell_flg[g]),
      .val       (cell_val[g]),
      .val_next  (cell_nxt[g])
    );

    assign lt_vec[g] = cell_flg[g].lt;
    assign eq_vec[g] = cell_flg[g].eq;
  end

  spq_enc #(
    .DEPTH (DEPTH)
  ) u_enc (
    .lt  (lt_vec),
    .pos (enc_pos)
  );

  assign full  = (count >= CW'(DEPTH));
  assign found = |eq_vec;

  // Decode the command into cell controls and the result
  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    res_status = ST_OK;
    res_pos    = '0;
    count_next = count;
    unique case (cmd_mode)
      OP_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins     = busy;
          res_pos    = enc_pos;
          count_next = count + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          do_rem     = busy;
          res_pos    = enc_pos;
          count_next = count - CW'(1);
        end else begin
          res_status = ST_MISSING;
        end
      end
      default: begin
        if (found) begin
          res_pos = enc_pos;
        end else begin
          res_status = ST_MISSING;
        end
      end
    endcase
  end

  always_comb begin
    ctrl.ins = do_ins;
    ctrl.rem = do_rem;
    ctrl.key = cmd_key;
  end

  assign res_pos_wide = 32'(res_pos);
  assign res_cnt_wide = 32'(count_next);

  // Advance the count on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (busy) begin
      count <= count_next;
    end
  end

  // Result register: fill on execute, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (busy) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      status      <= res_status;
      position    <= res_pos_wide[POS_W-1:0];
      head_value  <= (count_next != '0) ? cell_nxt[0] : '0;
      queue_empty <= (count_next == '0);
      entry_count <= res_cnt_wide[CNT_W-1:0];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(busy && out_valid))
    else $error("execute while a result still waits");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> out_valid)
    else $error("execute gave no result beat");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (busy && cmd_mode == OP_INSERT && !full) |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (queue_empty == (count == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

`default_nettype wire
